// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg : shared types and codes of the sorted priority queue
// Entry layout, operation codes and the control bundle that is broadcast to
// every cell of the row.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PrioW   = 8;
  localparam int AgeW    = 7;
  localparam int HealthW = 8;
  localparam int FuncW   = 2;

  typedef enum logic [FuncW-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_FRONT  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [PrioW-1:0]   prio;
    logic [AgeW-1:0]    age;
    logic [HealthW-1:0] health;
  } payload_t;

  typedef struct packed {
    logic     occ;
    payload_t data;
  } entry_t;

  // Broadcast to all cells; ins and pop are never high together.
  typedef struct packed {
    logic ins;
    logic pop;
  } ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell : one slot of the sorted entry row
// Holds one entry; on insert it keeps, shifts in its left neighbor or takes
// the new entry, on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spq_pkg::ctl_t    ctl,
  input  spq_pkg::payload_t new_ent,
  input  spq_pkg::entry_t  left,
  input  logic             left_lt,
  input  spq_pkg::entry_t  right,
  output spq_pkg::entry_t  q,
  output logic             lt
);
  import spq_pkg::*;

  logic     occ_r, occ_nxt;
  payload_t data_r, data_nxt;

  // New entry goes strictly in front of this one.
  assign lt = occ_r && (new_ent.prio < data_r.prio);

  always_comb begin
    occ_nxt  = occ_r;
    data_nxt = data_r;
    if (ctl.ins) begin
      if (left_lt) begin
        // shift right: left neighbor moves in
        occ_nxt  = 1'b1;
        data_nxt = left.data;
      end else if ((FIRST || left.occ) && (lt || !occ_r)) begin
        occ_nxt  = 1'b1;
        data_nxt = new_ent;
      end
    end else if (ctl.pop) begin
      occ_nxt  = right.occ;
      data_nxt = right.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = '{occ: occ_r, data: data_r};

endmodule

// ===== sv/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue : bounded priority queue in a row of sorting cells
// Entries sit in ascending priority order, front in cell 0. Insert places the
// new entry behind all entries of lower or equal priority; pop removes the
// front. Every operation yields one result beat.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | in_func, in_priority_req, in_age,
//          |                     | in_health_condition
//  out     | out_valid/out_stall | out_ok, out_is_empty, out_is_full,
//          |                     | out_priority, out_age, out_health
//
//  One beat per clock unless in_stall is high: every cell decides its next
//  entry in the cycle of acceptance from a broadcast compare against the new
//  priority, so the row is settled at the next edge, together with the
//  registered result. in_stall is high only while a result is held and
//  out_stall is high. Reset empties the row at once (occupancy bits only).
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spq_pkg::FuncW-1:0]   in_func,
  input  logic [spq_pkg::PrioW-1:0]   in_priority_req,
  input  logic [spq_pkg::AgeW-1:0]    in_age,
  input  logic [spq_pkg::HealthW-1:0] in_health_condition,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output logic [spq_pkg::PrioW-1:0]   out_priority,
  output logic [spq_pkg::AgeW-1:0]    out_age,
  output logic [spq_pkg::HealthW-1:0] out_health
);
  import spq_pkg::*;

  entry_t   cell_q  [CAPACITY];
  logic     cell_lt [CAPACITY];
  payload_t new_ent;
  ctl_t     ctl;
  op_t      op;
  logic     accept;
  logic     empty, full;

  // result register
  logic     out_valid_r, out_valid_nxt;
  logic     ok_r, ok_nxt;
  logic     empty_r, empty_nxt;
  logic     full_r, full_nxt;
  payload_t res_r, res_nxt;

  assign new_ent = '{prio: in_priority_req, age: in_age, health: in_health_condition};
  assign op      = op_t'(in_func);

  // Occupancy is a thermometer: cell 0 tells empty, the last cell full.
  assign empty = !cell_q[0].occ;
  assign full  = cell_q[CAPACITY-1].occ;

  // Accept whenever the result register is free or drains this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ctl.ins = accept && (op == OP_INSERT) && !full;
    ctl.pop = accept && (op == OP_POP) && !empty;
  end

  // The row of cells; cell 0 has no left neighbor, the last cell takes an
  // empty slot from the right on pop.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_lt;

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_lt  = 1'b0;
    end else begin : g_mid
      assign left_ent = cell_q[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = cell_q[i+1];
    end

    spq_cell #(
      .FIRST (i == 0)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .new_ent (new_ent),
      .left    (left_ent),
      .left_lt (left_lt),
      .right   (right_ent),
      .q       (cell_q[i]),
      .lt      (cell_lt[i])
    );
  end

  // Build the result beat from the state before the edge plus the operation.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    ok_nxt        = ok_r;
    empty_nxt     = empty_r;
    full_nxt      = full_r;
    res_nxt       = res_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = 1'b0;
      empty_nxt     = empty;
      full_nxt      = full;
      res_nxt       = empty ? '0 : cell_q[0].data;
      case (op)
        OP_INSERT: begin
          if (!full) begin
            ok_nxt    = 1'b1;
            empty_nxt = 1'b0;
            full_nxt  = cell_q[CAPACITY-2].occ;
            // new entry becomes the front if it beats the current one or the row is empty
            if (empty || cell_lt[0]) begin
              res_nxt = new_ent;
            end
          end
        end
        OP_POP: begin
          if (!empty) begin
            ok_nxt    = 1'b1;
            empty_nxt = !cell_q[1].occ;
            full_nxt  = 1'b0;
          end
        end
        OP_FRONT: begin
          ok_nxt = !empty;
        end
        default: begin
          // unused code: report the front, change nothing
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled.
  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    empty_r <= empty_nxt;
    full_r  <= full_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = ok_r;
  assign out_is_empty = empty_r;
  assign out_is_full  = full_r;
  assign out_priority = res_r.prio;
  assign out_age      = res_r.age;
  assign out_health   = res_r.health;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for sorted_priority_queue
// Drives insert, pop, front and unused operations into the queue in bursts,
// stalls the result channel on a changing pattern, and compares every result
// beat against a sorted software queue that is updated at each accepted beat.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int RANDOM_OPS    = 1150;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 4;

  // One operation as it travels on the input channel.
  typedef struct {
    op_t      func;
    payload_t data;
  } queue_op_t;

  // One result beat as the queue should report it.
  typedef struct {
    logic     ok;
    logic     is_empty;
    logic     is_full;
    payload_t shown;
  } queue_result_t;

  // Result-side backpressure styles; one is picked per stretch of cycles.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FuncW-1:0]    in_func = '0;
  logic [PrioW-1:0]    in_priority_req = '0;
  logic [AgeW-1:0]     in_age = '0;
  logic [HealthW-1:0]  in_health_condition = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_ok;
  logic                out_is_empty;
  logic                out_is_full;
  logic [PrioW-1:0]    out_priority;
  logic [AgeW-1:0]     out_age;
  logic [HealthW-1:0]  out_health;

  queue_op_t     pending_ops[$];       // filled up front, drained by the driver
  queue_result_t expected_results[$];  // one per accepted beat, oldest first
  payload_t      held_entries[$];      // predicted queue contents, front first
  queue_op_t     driven_op;            // operation currently on the input port

  int unsigned   error_count = 0;
  int unsigned   result_count = 0;
  int unsigned   cycle_count = 0;

  sorted_priority_queue #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_priority_req    (in_priority_req),
    .in_age             (in_age),
    .in_health_condition(in_health_condition),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_is_empty       (out_is_empty),
    .out_is_full        (out_is_full),
    .out_priority       (out_priority),
    .out_age            (out_age),
    .out_health         (out_health)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one operation to the predicted queue and return the result beat it
  // must produce. Pop shows the removed entry; everything else shows the
  // front after the operation, or zeros when the queue is empty.
  function automatic queue_result_t predict_queue_op(queue_op_t op);
    queue_result_t r;
    int            pos;
    r.ok    = 1'b0;
    r.shown = '0;
    case (op.func)
      OP_INSERT: begin
        // Refuse when full; otherwise sit behind every lower-or-equal priority.
        if (held_entries.size() < CAPACITY) begin
          pos = held_entries.size();
          while (pos > 0 && op.data.prio < held_entries[pos-1].prio) pos--;
          held_entries.insert(pos, op.data);
          r.ok = 1'b1;
        end
        if (held_entries.size() > 0) r.shown = held_entries[0];
      end
      OP_POP: begin
        if (held_entries.size() > 0) begin
          r.shown = held_entries.pop_front();
          r.ok    = 1'b1;
        end
      end
      OP_FRONT: begin
        if (held_entries.size() > 0) begin
          r.shown = held_entries[0];
          r.ok    = 1'b1;
        end
      end
      default: begin
        // Unused code: no state change, front is still reported.
        if (held_entries.size() > 0) r.shown = held_entries[0];
      end
    endcase
    r.is_empty = (held_entries.size() == 0);
    r.is_full  = (held_entries.size() >= CAPACITY);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t ns: result %0d field %s got %0d want %0d",
             $time, result_count, field, got, want);
    error_count++;
  endtask

  task automatic push_op(op_t func, int prio, int age, int health);
    queue_op_t op;
    op.func        = func;
    op.data.prio   = PrioW'(prio);
    op.data.age    = AgeW'(age);
    op.data.health = HealthW'(health);
    pending_ops.push_back(op);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: a directed opening, then random phases, then wait for drain.
  // --------------------------------------------------------------------------
  initial begin
    int          made;
    int          phase_len;
    int          w_insert;
    int          w_pop;
    int          pick;
    bit          narrow;
    int          prio_base;
    op_t         func;
    int          prio;

    // Empty-queue cases: front and pop fail, unused code does nothing.
    push_op(OP_FRONT, 8'hFF, 7'h7F, 8'hFF);
    push_op(OP_POP, 0, 0, 0);
    push_op(OP_NONE, 8'hFF, 7'h7F, 8'hFF);
    // Fill to capacity with extremes, a new front, and ties that must keep
    // arrival order.
    push_op(OP_INSERT, 128, 0, 0);
    push_op(OP_INSERT, 0, 127, 255);
    push_op(OP_INSERT, 255, 127, 255);
    push_op(OP_INSERT, 128, 1, 170);
    push_op(OP_INSERT, 128, 2, 85);
    for (int i = 0; i < 11; i++) begin
      push_op(OP_INSERT, (i * 23) % 256, 64 + i, 255 - i * 7);
    end
    // Full-queue cases: refused insert of a would-be front, then no-op, peek, pops.
    push_op(OP_INSERT, 0, 0, 0);
    push_op(OP_NONE, 0, 0, 0);
    push_op(OP_FRONT, 0, 0, 0);
    push_op(OP_POP, 0, 0, 0);
    push_op(OP_POP, 0, 0, 0);
    push_op(OP_POP, 0, 0, 0);

    // Random part: phases that lean toward filling, draining or neither, so
    // the queue keeps running into both full and empty. Narrow priority
    // windows force plenty of ties.
    made = 0;
    while (made < RANDOM_OPS) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       begin w_insert = 75; w_pop = 15; end
        1:       begin w_insert = 20; w_pop = 70; end
        default: begin w_insert = 45; w_pop = 45; end
      endcase
      narrow    = ($urandom_range(0, 1) == 1);
      prio_base = $urandom_range(0, 252);
      for (int i = 0; i < phase_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < w_insert)              func = OP_INSERT;
        else if (pick < w_insert + w_pop) func = OP_POP;
        else if (pick < 97)               func = OP_FRONT;
        else                              func = OP_NONE;
        prio = narrow ? prio_base + $urandom_range(0, 3) : $urandom_range(0, 255);
        push_op(func, prio, $urandom_range(0, 127), $urandom_range(0, 255));
        made++;
      end
    end

    // Hold reset at the start, then release it once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go in and every result to come back.
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: send in bursts of random length with random gaps. Hold the beat
  // while stalled; predict the result at the edge where a beat is accepted.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_queue_op(driven_op));
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat unchanged
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        driven_op           = pending_ops.pop_front();
        in_func             <= driven_op.func;
        in_priority_req     <= driven_op.data.prio;
        in_age              <= driven_op.data.age;
        in_health_condition <= driven_op.data.health;
        in_valid            <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // End of burst: schedule the next gap, sometimes none at all.
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side stall pattern: switch between no stall, light, heavy and
  // periodic backpressure in phases of random length.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_phase_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode       = stall_mode_t'($urandom_range(0, 3));
        stall_phase_left = $urandom_range(20, 80);
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= ((cycle_count % 7) < 4);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result beat with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected_beat", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_ok !== want.ok)
          report_mismatch("ok", out_ok, want.ok);
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", out_is_empty, want.is_empty);
        if (out_is_full !== want.is_full)
          report_mismatch("is_full", out_is_full, want.is_full);
        if (out_priority !== want.shown.prio)
          report_mismatch("priority", out_priority, want.shown.prio);
        if (out_age !== want.shown.age)
          report_mismatch("age", out_age, want.shown.age);
        if (out_health !== want.shown.health)
          report_mismatch("health", out_health, want.shown.health);
      end
      result_count++;
    end
  end

  // Watchdog: end the run with a failure once cycle_count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
bench/tb.sv
